// ===== design/sip_pkg.sv =====
// Shared types and defaults for the segment intersection point core.
// No dependencies; imported by the core, its divider and its checker.
package sip_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Pipeline control handed to the divider: advance enable and entry valid.
    typedef struct packed {
        logic adv;
        logic vld;
    } sip_ctl_t;

endpackage

// ===== design/segment_intersection_point_core.sv =====
// Segment pair crossing point: top level of the pipelined core.
// Depends on sip_pkg and instantiates sip_div for the rounding division.
//
// Usage:
//   Slave channel s_*: one request carries two segments (top and bottom
//   point each, signed COORD_BITS coordinates) in s_tdata and the shared
//   vertex flag in s_tuser. Master channel m_*: one result per request,
//   hit flag in m_tuser, rounded crossing x and y in m_tdata (zero on miss).
//   Pipeline: six stages of line coefficients, cross products, sign
//   normalization and the product s*k, then COORD_BITS divider stages (one
//   quotient bit each), then two rounding stages ending in the output
//   register.
//   Throughput: one request per cycle while the output is not stalled;
//   every stage is a plain register with a valid bit, so a new pair may
//   enter every cycle unless a stalled result holds the pipeline.
//   Reset clears all valid bits at once; the block takes requests right
//   after reset is released.
//   Stall: when the output register holds a result that the receiver does
//   not take, the whole pipeline holds and s_tready drops; nothing is
//   dropped or repeated, and s_tready stays high while the output is empty
//   or being taken.
module segment_intersection_point_core
    import sip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // first_top_x, first_top_y, first_bottom_x, first_bottom_y,
    // second_top_x, second_top_y, second_bottom_x, second_bottom_y
    input  logic [((8*COORD_BITS+7)/8)*8-1:0]         s_tdata,
    // shares_endpoint
    input  logic                                      s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // cross_x, cross_y, zero fill
    output logic [((2*COORD_BITS+7)/8)*8-1:0]         m_tdata,
    // hit
    output logic                                      m_tuser
);

    localparam int N      = COORD_BITS;
    localparam int OUT_W  = ((2*COORD_BITS+7)/8)*8;
    localparam int DIFF_W = N + 1;       // coordinate differences
    localparam int PROD_W = 2*N + 2;     // cross products and their sums
    localparam int UW     = 2*N + 1;     // normalized magnitudes
    localparam int LO_W   = N + 1;       // low slice of s for the split multiply
    localparam int PPL_W  = 2*N + 1;
    localparam int PPH_W  = 2*N;
    localparam int P_W    = 3*N + 1;     // dividend s*|k|
    localparam int IP_W   = N + 2;       // base +/- quotient
    localparam int TAG_W  = 2*N + 3;     // kill, y sign, y base, x sign, x base

    logic adv;

    // ---------------------------------------------------------------
    // Stage 1: unpack, differences, bounding box and shared vertex reject
    // ---------------------------------------------------------------
    logic signed [N-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic                box_miss;

    assign x1 = s_tdata[1*N-1:0*N];
    assign y1 = s_tdata[2*N-1:1*N];
    assign x2 = s_tdata[3*N-1:2*N];
    assign y2 = s_tdata[4*N-1:3*N];
    assign x3 = s_tdata[5*N-1:4*N];
    assign y3 = s_tdata[6*N-1:5*N];
    assign x4 = s_tdata[7*N-1:6*N];
    assign y4 = s_tdata[8*N-1:7*N];

    always_comb
    begin
        logic signed [N-1:0] min_x12, max_x12, min_x34, max_x34;
        logic signed [N-1:0] min_y12, max_y12, min_y34, max_y34;
        min_x12 = (x1 < x2) ? x1 : x2;
        max_x12 = (x1 > x2) ? x1 : x2;
        min_x34 = (x3 < x4) ? x3 : x4;
        max_x34 = (x3 > x4) ? x3 : x4;
        min_y12 = (y1 < y2) ? y1 : y2;
        max_y12 = (y1 > y2) ? y1 : y2;
        min_y34 = (y3 < y4) ? y3 : y4;
        max_y34 = (y3 > y4) ? y3 : y4;
        box_miss = (min_x12 > max_x34) || (max_x12 < min_x34) ||
                   (min_y12 > max_y34) || (max_y12 < min_y34);
    end

    logic                     v1_reg;
    logic signed [DIFF_W-1:0] a1_reg, b1_reg, oa1_reg, ob1_reg, dx1_reg, dy1_reg;
    logic signed [N-1:0]      bx1_reg, by1_reg;
    logic                     kill1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg    <= DIFF_W'(y2) - DIFF_W'(y1);
            b1_reg    <= DIFF_W'(x1) - DIFF_W'(x2);
            oa1_reg   <= DIFF_W'(y4) - DIFF_W'(y3);
            ob1_reg   <= DIFF_W'(x3) - DIFF_W'(x4);
            dx1_reg   <= DIFF_W'(x3) - DIFF_W'(x1);
            dy1_reg   <= DIFF_W'(y3) - DIFF_W'(y1);
            bx1_reg   <= x1;
            by1_reg   <= y1;
            kill1_reg <= s_tuser || box_miss;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: the six cross products, magnitudes of the slopes
    // ---------------------------------------------------------------
    logic                     v2_reg;
    logic signed [PROD_W-1:0] pa_ob_reg, pb_oa_reg, pdy_ob_reg, pdx_oa_reg;
    logic signed [PROD_W-1:0] pdy_b_reg, pdx_a_reg;
    logic [N-1:0]             kx2_reg, ky2_reg;
    logic                     kxn2_reg, kyn2_reg;
    logic signed [N-1:0]      bx2_reg, by2_reg;
    logic                     kill2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_ob_reg  <= a1_reg * ob1_reg;
            pb_oa_reg  <= b1_reg * oa1_reg;
            pdy_ob_reg <= dy1_reg * ob1_reg;
            pdx_oa_reg <= dx1_reg * oa1_reg;
            pdy_b_reg  <= dy1_reg * b1_reg;
            pdx_a_reg  <= dx1_reg * a1_reg;
            // x steps along -b, y steps along a
            kxn2_reg   <= (b1_reg > 0);
            kx2_reg    <= (b1_reg < 0) ? N'(-b1_reg) : N'(b1_reg);
            kyn2_reg   <= a1_reg[DIFF_W-1];
            ky2_reg    <= a1_reg[DIFF_W-1] ? N'(-a1_reg) : N'(a1_reg);
            bx2_reg    <= bx1_reg;
            by2_reg    <= by1_reg;
            kill2_reg  <= kill1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: denominator and both numerators
    // ---------------------------------------------------------------
    logic                     v3_reg;
    logic signed [PROD_W-1:0] den3_reg, s3_reg, t3_reg;
    logic [N-1:0]             kx3_reg, ky3_reg;
    logic                     kxn3_reg, kyn3_reg;
    logic signed [N-1:0]      bx3_reg, by3_reg;
    logic                     kill3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den3_reg  <= pa_ob_reg - pb_oa_reg;
            s3_reg    <= pdy_ob_reg + pdx_oa_reg;
            t3_reg    <= pdy_b_reg + pdx_a_reg;
            kx3_reg   <= kx2_reg;
            ky3_reg   <= ky2_reg;
            kxn3_reg  <= kxn2_reg;
            kyn3_reg  <= kyn2_reg;
            bx3_reg   <= bx2_reg;
            by3_reg   <= by2_reg;
            kill3_reg <= kill2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: make the denominator positive, check both parameters
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] den_n, s_n, t_n;
    logic                     range_miss;

    always_comb
    begin
        den_n = den3_reg[PROD_W-1] ? -den3_reg : den3_reg;
        s_n   = den3_reg[PROD_W-1] ? -s3_reg   : s3_reg;
        t_n   = den3_reg[PROD_W-1] ? -t3_reg   : t3_reg;
        range_miss = (den3_reg == '0) || s_n[PROD_W-1] || (s_n > den_n) ||
                     t_n[PROD_W-1] || (t_n > den_n);
    end

    logic                v4_reg;
    logic [UW-1:0]       den4_reg, s4_reg;
    logic [N-1:0]        kx4_reg, ky4_reg;
    logic                kxn4_reg, kyn4_reg;
    logic signed [N-1:0] bx4_reg, by4_reg;
    logic                kill4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den4_reg  <= den_n[UW-1:0];
            s4_reg    <= s_n[UW-1:0];
            kx4_reg   <= kx3_reg;
            ky4_reg   <= ky3_reg;
            kxn4_reg  <= kxn3_reg;
            kyn4_reg  <= kyn3_reg;
            bx4_reg   <= bx3_reg;
            by4_reg   <= by3_reg;
            kill4_reg <= kill3_reg || range_miss;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: s * |k| as two partial products per axis
    // ---------------------------------------------------------------
    logic [LO_W-1:0]     s_lo;
    logic [N-1:0]        s_hi;

    assign s_lo = s4_reg[LO_W-1:0];
    assign s_hi = s4_reg[UW-1:LO_W];

    logic                v5_reg;
    logic [PPL_W-1:0]    pplx5_reg, pply5_reg;
    logic [PPH_W-1:0]    pphx5_reg, pphy5_reg;
    logic [UW-1:0]       den5_reg;
    logic                kxn5_reg, kyn5_reg;
    logic signed [N-1:0] bx5_reg, by5_reg;
    logic                kill5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pplx5_reg <= PPL_W'(s_lo) * PPL_W'(kx4_reg);
            pply5_reg <= PPL_W'(s_lo) * PPL_W'(ky4_reg);
            pphx5_reg <= PPH_W'(s_hi) * PPH_W'(kx4_reg);
            pphy5_reg <= PPH_W'(s_hi) * PPH_W'(ky4_reg);
            den5_reg  <= den4_reg;
            kxn5_reg  <= kxn4_reg;
            kyn5_reg  <= kyn4_reg;
            bx5_reg   <= bx4_reg;
            by5_reg   <= by4_reg;
            kill5_reg <= kill4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: combine partial products into the dividends
    // ---------------------------------------------------------------
    logic                v6_reg;
    logic [P_W-1:0]      px6_reg, py6_reg;
    logic [UW-1:0]       den6_reg;
    logic [TAG_W-1:0]    tag6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px6_reg  <= P_W'(pplx5_reg) + (P_W'(pphx5_reg) << LO_W);
            py6_reg  <= P_W'(pply5_reg) + (P_W'(pphy5_reg) << LO_W);
            den6_reg <= den5_reg;
            tag6_reg <= {kill5_reg, kyn5_reg, by5_reg, kxn5_reg, bx5_reg};
        end
    end

    // ---------------------------------------------------------------
    // Divider: quotient and remainder of s*|k| / den for both axes
    // ---------------------------------------------------------------
    sip_ctl_t                     div_ctl;
    logic                         dv_vld;
    logic [1:0][N-1:0]            dv_quo;
    logic [1:0][UW-1:0]           dv_rem;
    logic [UW-1:0]                dv_den;
    logic [TAG_W-1:0]             dv_tag;

    assign div_ctl.adv = adv;
    assign div_ctl.vld = v6_reg;

    sip_div #(
        .LANES     (2),
        .DIVISOR_W (UW),
        .QUO_W     (N),
        .TAG_W     (TAG_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (div_ctl),
        .dividend    ({py6_reg, px6_reg}),
        .divisor     (den6_reg),
        .tag         (tag6_reg),
        .out_vld     (dv_vld),
        .quo         (dv_quo),
        .rem         (dv_rem),
        .out_divisor (dv_den),
        .out_tag     (dv_tag)
    );

    // ---------------------------------------------------------------
    // Rounding stage 1: truncated point, remainder against half divisor
    // ---------------------------------------------------------------
    logic                 t_kill, t_kxn, t_kyn;
    logic signed [N-1:0]  t_bx, t_by;

    assign t_bx   = dv_tag[N-1:0];
    assign t_kxn  = dv_tag[N];
    assign t_by   = dv_tag[2*N:N+1];
    assign t_kyn  = dv_tag[2*N+1];
    assign t_kill = dv_tag[2*N+2];

    logic                   vr_reg;
    logic signed [IP_W-1:0] ipx_reg, ipy_reg;
    logic                   upx_reg, upy_reg, tiex_reg, tiey_reg;
    logic                   negx_reg, negy_reg;
    logic                   hitr_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ipx_reg  <= t_kxn ? IP_W'(t_bx) - $signed({2'b00, dv_quo[0]})
                              : IP_W'(t_bx) + $signed({2'b00, dv_quo[0]});
            ipy_reg  <= t_kyn ? IP_W'(t_by) - $signed({2'b00, dv_quo[1]})
                              : IP_W'(t_by) + $signed({2'b00, dv_quo[1]});
            upx_reg  <= {dv_rem[0], 1'b0} >  {1'b0, dv_den};
            upy_reg  <= {dv_rem[1], 1'b0} >  {1'b0, dv_den};
            tiex_reg <= {dv_rem[0], 1'b0} == {1'b0, dv_den};
            tiey_reg <= {dv_rem[1], 1'b0} == {1'b0, dv_den};
            negx_reg <= t_kxn;
            negy_reg <= t_kyn;
            hitr_reg <= !t_kill;
        end
    end

    // Step one unit along the slope when past half; on an exact half step
    // only when that moves away from zero.
    function automatic logic [N-1:0] round_fix(
        input logic signed [IP_W-1:0] ip,
        input logic                   up,
        input logic                   tie,
        input logic                   neg
    );
        logic signed [IP_W-1:0] ip_inc;
        logic signed [IP_W-1:0] ip_dec;
        logic signed [IP_W-1:0] res;
        ip_inc = ip + IP_W'(1);
        ip_dec = ip - IP_W'(1);
        priority if (up)
            res = neg ? ip_dec : ip_inc;
        else if (tie && !neg)
            res = ip[IP_W-1] ? ip : ip_inc;
        else if (tie && neg)
            res = (ip[IP_W-1] || ip == '0) ? ip_dec : ip;
        else
            res = ip;
        return res[N-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Rounding stage 2 and output register
    // ---------------------------------------------------------------
    logic                out_vld_reg;
    logic [N-1:0]        cx_reg, cy_reg;
    logic                hit_reg;

    assign adv = !out_vld_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg  <= hitr_reg ? round_fix(ipx_reg, upx_reg, tiex_reg, negx_reg) : '0;
            cy_reg  <= hitr_reg ? round_fix(ipy_reg, upy_reg, tiey_reg, negy_reg) : '0;
            hit_reg <= hitr_reg;
        end
    end

    // Valid bits: hold on stall, advance otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            vr_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg      <= s_tvalid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            vr_reg      <= dv_vld;
            out_vld_reg <= vr_reg;
        end
    end

    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'({cy_reg, cx_reg});
    assign m_tuser  = hit_reg;

endmodule

// ===== design/sip_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Depends on sip_pkg for the control struct.
module sip_div
    import sip_pkg::*;
#(
    parameter int LANES     = 2,
    parameter int DIVISOR_W = 33,
    parameter int QUO_W     = 16,
    parameter int TAG_W     = 35
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  sip_ctl_t                                   ctl,
    input  logic [LANES-1:0][DIVISOR_W+QUO_W-1:0]      dividend,
    input  logic [DIVISOR_W-1:0]                       divisor,
    input  logic [TAG_W-1:0]                           tag,
    output logic                                       out_vld,
    output logic [LANES-1:0][QUO_W-1:0]                quo,
    output logic [LANES-1:0][DIVISOR_W-1:0]            rem,
    output logic [DIVISOR_W-1:0]                       out_divisor,
    output logic [TAG_W-1:0]                           out_tag
);

    localparam int DIVIDEND_W = DIVISOR_W + QUO_W;

    logic [QUO_W-1:0]                     vld_reg;
    logic [LANES-1:0][DIVISOR_W-1:0]      rem_reg  [QUO_W];
    logic [LANES-1:0][DIVISOR_W-1:0]      rem_next [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]          low_reg  [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]          low_next [QUO_W];
    logic [DIVISOR_W-1:0]                 dsr_reg  [QUO_W];
    logic [TAG_W-1:0]                     tag_reg  [QUO_W];

    // Each stage shifts one dividend bit into the partial remainder and
    // subtracts the divisor when it fits; the quotient bit fills in from below.
    always_comb
    begin : step_logic
        logic [DIVISOR_W-1:0] rem_in;
        logic [QUO_W-1:0]     low_in;
        logic [DIVISOR_W-1:0] dsr_in;
        logic [DIVISOR_W:0]   cand;
        logic [DIVISOR_W:0]   diff;
        logic                 qbit;
        for (int st = 0; st < QUO_W; st++)
        begin
            for (int ln = 0; ln < LANES; ln++)
            begin
                if (st == 0)
                begin
                    rem_in = dividend[ln][DIVIDEND_W-1:QUO_W];
                    low_in = dividend[ln][QUO_W-1:0];
                    dsr_in = divisor;
                end
                else
                begin
                    rem_in = rem_reg[st-1][ln];
                    low_in = low_reg[st-1][ln];
                    dsr_in = dsr_reg[st-1];
                end
                cand = {rem_in, low_in[QUO_W-1]};
                diff = cand - {1'b0, dsr_in};
                qbit = (cand >= {1'b0, dsr_in});
                rem_next[st][ln] = qbit ? diff[DIVISOR_W-1:0] : cand[DIVISOR_W-1:0];
                low_next[st][ln] = {low_in[QUO_W-2:0], qbit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= {vld_reg[QUO_W-2:0], ctl.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int st = 0; st < QUO_W; st++)
            begin
                rem_reg[st] <= rem_next[st];
                low_reg[st] <= low_next[st];
                if (st == 0)
                begin
                    dsr_reg[st] <= divisor;
                    tag_reg[st] <= tag;
                end
                else
                begin
                    dsr_reg[st] <= dsr_reg[st-1];
                    tag_reg[st] <= tag_reg[st-1];
                end
            end
        end
    end

    assign out_vld     = vld_reg[QUO_W-1];
    assign quo         = low_reg[QUO_W-1];
    assign rem         = rem_reg[QUO_W-1];
    assign out_divisor = dsr_reg[QUO_W-1];
    assign out_tag     = tag_reg[QUO_W-1];

endmodule

// ===== design/sip_chk.sv =====
// Port-level checker for the segment intersection point core, with its bind.
// Depends on sip_pkg for the default coordinate width.
module sip_chk
    import sip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0]  m_tdata,
    input logic                               m_tuser
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A miss reports a zero point.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with nonzero point");

    // An empty output register never blocks new requests.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("ready low with empty output");

    // A receiver that takes results never stalls the sender.
    a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("ready low while receiver ready");

    // Ready only drops because a result is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("ready low without output stall");

endmodule

bind segment_intersection_point_core sip_chk #(.COORD_BITS(COORD_BITS)) u_sip_chk (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for segment_intersection_point_core: stream requests in, results out.
// Depends on sip_pkg and the core RTL. It predicts every crossing point with its own model
// and compares the results in order, with random stalls on both sides.
module tb
    import sip_pkg::*;
;

    localparam int CB       = COORD_BITS_DEF;
    localparam int HI       = (1 << (CB - 1)) - 1;
    localparam int LO       = -(1 << (CB - 1));
    localparam int N_RANDOM = 830;
    localparam int HOLD_AT  = 310;       // requests sent before the long receiver hold-off
    localparam int HOLD_LEN = 150;       // cycles of the long hold-off
    localparam int DRAIN_AT = 520;       // request index that waits for an empty pipeline
    localparam int SETTLE   = CB + 16;   // cycles to wait out after the last result
    localparam int MAX_LOGS = 50;

    // One request: two segments and the shared vertex flag.
    typedef struct {
        logic signed [CB-1:0] x1, y1, x2, y2;   // first segment, top then bottom
        logic signed [CB-1:0] x3, y3, x4, y4;   // second segment, top then bottom
        logic                 shared;
        bit                   drain_first;      // hold this request until nothing is in flight
    } seg_pair_t;

    typedef struct {
        logic          hit;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } crossing_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // first_top_x, first_top_y, first_bottom_x, first_bottom_y,
    // second_top_x, second_top_y, second_bottom_x, second_bottom_y
    logic [((8*CB+7)/8)*8-1:0]        s_tdata  = '0;
    // shares_endpoint
    logic                             s_tuser  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // cross_x, cross_y, zero fill
    logic [((2*CB+7)/8)*8-1:0]        m_tdata;
    // hit
    logic                             m_tuser;

    seg_pair_t pending_pairs[$];
    crossing_t exp_crossings[$];
    seg_pair_t cur_pair;

    int n_sent     = 0;
    int n_recv     = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int n_errors   = 0;
    int hold_left  = 0;
    bit hold_on    = 1'b0;
    bit hold_done  = 1'b0;

    segment_intersection_point_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hold reset low at the start, then release it for good.
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Generous fixed limit: far beyond the slowest correct run.
    initial
    begin
        #3200000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    // base + s*k/den, rounded to nearest with halves away from zero (s >= 0, den > 0).
    function automatic longint round_half_away(longint base, longint s, longint k, longint den);
        longint sg, mag, num, q, rem, ip;
        sg  = (k < 0) ? -1 : 1;
        mag = (k < 0) ? -k : k;
        num = s * mag;
        q   = num / den;
        rem = num % den;
        ip  = base + sg * q;
        if (rem == 0)
            return ip;
        if (2 * rem > den)
            return ip + sg;
        if (2 * rem < den)
            return ip;
        // Exact half: step away from zero.
        if (sg > 0)
            return (ip >= 0) ? ip + 1 : ip;
        return (ip <= 0) ? ip - 1 : ip;
    endfunction

    // Crossing point of one request, computed with exact integer arithmetic.
    function automatic crossing_t crossing_of(seg_pair_t p);
        crossing_t r;
        longint    x1, y1, x2, y2, x3, y3, x4, y4;
        longint    a, b, oa, ob, den, dx, dy, s, t;
        r.hit = 1'b0;
        r.x   = '0;
        r.y   = '0;
        x1 = longint'(p.x1); y1 = longint'(p.y1);
        x2 = longint'(p.x2); y2 = longint'(p.y2);
        x3 = longint'(p.x3); y3 = longint'(p.y3);
        x4 = longint'(p.x4); y4 = longint'(p.y4);
        if (p.shared)
            return r;
        // Drop pairs whose bounding boxes do not touch.
        if (lmin(x1, x2) > lmax(x3, x4) || lmax(x1, x2) < lmin(x3, x4) ||
            lmin(y1, y2) > lmax(y3, y4) || lmax(y1, y2) < lmin(y3, y4))
            return r;
        a   = y2 - y1;
        b   = x1 - x2;
        oa  = y4 - y3;
        ob  = x3 - x4;
        den = a * ob - b * oa;
        if (den == 0)
            return r;
        dx = x3 - x1;
        dy = y3 - y1;
        s  = dy * ob + dx * oa;
        t  = dy * b + dx * a;
        if (den < 0)
        begin
            den = -den;
            s   = -s;
            t   = -t;
        end
        if (s < 0 || s > den || t < 0 || t > den)
            return r;
        r.hit = 1'b1;
        r.x   = CB'(round_half_away(x1, s, -b, den));
        r.y   = CB'(round_half_away(y1, s, a, den));
        return r;
    endfunction

    function automatic seg_pair_t seg_pair(int x1, int y1, int x2, int y2,
                                           int x3, int y3, int x4, int y4, bit sh);
        seg_pair_t p;
        p.x1 = x1[CB-1:0]; p.y1 = y1[CB-1:0]; p.x2 = x2[CB-1:0]; p.y2 = y2[CB-1:0];
        p.x3 = x3[CB-1:0]; p.y3 = y3[CB-1:0]; p.x4 = x4[CB-1:0]; p.y4 = y4[CB-1:0];
        p.shared      = sh;
        p.drain_first = 1'b0;
        return p;
    endfunction

    function automatic logic [((8*CB+7)/8)*8-1:0] pack_pair(seg_pair_t p);
        logic [((8*CB+7)/8)*8-1:0] d;
        d = '0;
        d[8*CB-1:0] = {p.y4, p.x4, p.y3, p.x3, p.y2, p.x2, p.y1, p.x1};
        return d;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 4))
            0:       return LO;
            1:       return HI;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom_range(0, 2 * HI + 1)) + LO;
        endcase
    endfunction

    // Random request: mostly pairs that come close to each other, some wide noise.
    function automatic seg_pair_t rand_pair();
        int c[8];
        int r, cx, cy, dx1, dy1, dx2, dy2, mode, i;
        mode = $urandom_range(0, 9);
        if (mode < 4)
        begin
            // Both segments inside one box around a random center.
            case ($urandom_range(0, 3))
                0:       r = 3;
                1:       r = 40;
                2:       r = 2000;
                default: r = HI;
            endcase
            cx = int'($urandom_range(0, 2 * (HI - r))) - (HI - r);
            cy = int'($urandom_range(0, 2 * (HI - r))) - (HI - r);
            for (i = 0; i < 8; i++)
                c[i] = ((i % 2 == 0) ? cx : cy) + int'($urandom_range(0, 2 * r)) - r;
        end
        else if (mode < 6)
        begin
            for (i = 0; i < 8; i++)
                c[i] = int'($urandom_range(0, 2 * HI + 1)) + LO;
        end
        else if (mode < 9)
        begin
            // Two segments through one point, each end nudged so crossings land off-grid.
            cx  = int'($urandom_range(0, HI)) - HI / 2;
            cy  = int'($urandom_range(0, HI)) - HI / 2;
            dx1 = int'($urandom_range(0, HI / 2)) - HI / 4;
            dy1 = int'($urandom_range(0, HI / 2)) - HI / 4;
            dx2 = int'($urandom_range(0, HI / 2)) - HI / 4;
            dy2 = int'($urandom_range(0, HI / 2)) - HI / 4;
            c[0] = cx + dx1; c[1] = cy + dy1; c[2] = cx - dx1; c[3] = cy - dy1;
            c[4] = cx + dx2; c[5] = cy + dy2; c[6] = cx - dx2; c[7] = cy - dy2;
            for (i = 0; i < 8; i++)
                c[i] = c[i] + int'($urandom_range(0, 4)) - 2;
        end
        else
        begin
            for (i = 0; i < 8; i++)
                c[i] = extreme_coord();
        end
        return seg_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                        $urandom_range(0, 9) == 0);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (n_errors < MAX_LOGS)
            $display("mismatch on result %0d: %s got %0d expected %0d", n_recv, what, got, want);
        n_errors++;
    endtask

    // Driver: offer queued requests, idle between them, hold a request on a stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                exp_crossings.push_back(crossing_of(cur_pair));
                n_sent++;
                // Alternate stretches of random gaps with back-to-back requests.
                gap_left = ((n_sent / 100) % 2 == 1) ? 0 : int'($urandom_range(0, 14));
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_pairs.size() == 0)
                    s_tvalid <= 1'b0;
                else if (pending_pairs[0].drain_first && exp_crossings.size() != 0)
                    s_tvalid <= 1'b0;
                else
                begin
                    cur_pair  = pending_pairs.pop_front();
                    s_tdata  <= pack_pair(cur_pair);
                    s_tuser  <= cur_pair.shared;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the pipeline fills and s_tready drops.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                if (hold_left == 1)
                    hold_on <= 1'b0;
            end
            else if (!hold_done && n_sent >= HOLD_AT)
            begin
                hold_on   <= 1'b1;
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
            end
        end
    end

    // Monitor: take results with random stalls and check each against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (exp_crossings.size() == 0)
                    report_mismatch("unexpected result, hit", longint'(m_tuser), 0);
                else
                begin
                    crossing_t want;
                    want = exp_crossings.pop_front();
                    if (m_tuser !== want.hit)
                        report_mismatch("hit", longint'(m_tuser), longint'(want.hit));
                    if (m_tdata[CB-1:0] !== want.x)
                        report_mismatch("cross_x", longint'($signed(m_tdata[CB-1:0])),
                                        longint'($signed(want.x)));
                    if (m_tdata[2*CB-1:CB] !== want.y)
                        report_mismatch("cross_y", longint'($signed(m_tdata[2*CB-1:CB])),
                                        longint'($signed(want.y)));
                end
                n_recv++;
                stall_left = ((n_recv / 150) % 3 == 2) ? 0 : int'($urandom_range(0, 14));
            end
            if (hold_on)
                m_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        seg_pair_t p;
        int        i;

        // Shared vertex on an otherwise clean crossing.
        pending_pairs.push_back(seg_pair(0, 0, 10, 10, 0, 10, 10, 0, 1'b1));
        // Boxes apart in x, then in y.
        pending_pairs.push_back(seg_pair(0, 0, 10, 10, 11, 0, 20, 10, 1'b0));
        pending_pairs.push_back(seg_pair(0, 0, 10, 10, 0, 11, 10, 20, 1'b0));
        // Collinear overlap and a zero-length segment: zero denominator.
        pending_pairs.push_back(seg_pair(0, 0, 10, 10, 5, 5, 15, 15, 1'b0));
        pending_pairs.push_back(seg_pair(3, 3, 3, 3, 0, 0, 6, 6, 1'b0));
        pending_pairs.push_back(seg_pair(0, 0, 0, 10, 0, 5, 0, 15, 1'b0));
        // Boxes overlap but the lines cross outside the segments.
        pending_pairs.push_back(seg_pair(0, 0, 10, 10, 8, 0, 10, 1, 1'b0));
        // Plain X crossing on the grid.
        pending_pairs.push_back(seg_pair(0, 0, 10, 10, 0, 10, 10, 0, 1'b0));
        // Touching at an end point and a T touch: parameter on the boundary.
        pending_pairs.push_back(seg_pair(0, 0, 10, 10, 10, 10, 20, 0, 1'b0));
        pending_pairs.push_back(seg_pair(0, 0, 10, 0, 5, 0, 5, 10, 1'b0));
        // Exact halves on both sides of zero.
        pending_pairs.push_back(seg_pair(0, 0, 1, 1, 0, 1, 1, 0, 1'b0));
        pending_pairs.push_back(seg_pair(0, 0, -1, -1, 0, -1, -1, 0, 1'b0));
        pending_pairs.push_back(seg_pair(-3, -3, -2, -2, -3, -2, -2, -3, 1'b0));
        pending_pairs.push_back(seg_pair(2, 2, 3, 3, 2, 3, 3, 2, 1'b0));
        // Off-grid crossing that rounds to nearest.
        pending_pairs.push_back(seg_pair(0, 0, 7, 3, 0, 3, 5, 0, 1'b0));
        // Full-range diagonals and axes.
        pending_pairs.push_back(seg_pair(LO, LO, HI, HI, LO, HI, HI, LO, 1'b0));
        pending_pairs.push_back(seg_pair(HI, LO, LO, HI, LO, LO, HI, HI, 1'b0));
        pending_pairs.push_back(seg_pair(LO, 0, HI, 0, 0, LO, 0, HI, 1'b0));
        pending_pairs.push_back(seg_pair(LO, HI, HI, HI, HI, LO, HI, HI, 1'b0));
        // All coordinates at one extreme.
        pending_pairs.push_back(seg_pair(HI, HI, HI, HI, HI, HI, HI, HI, 1'b0));
        pending_pairs.push_back(seg_pair(LO, LO, LO, LO, LO, LO, LO, LO, 1'b1));

        for (i = 0; i < N_RANDOM; i++)
        begin
            p = rand_pair();
            // Pause the sender until the pipeline has drained, once at the start of the
            // random part and once in the middle.
            if (i == 0 || i == DRAIN_AT)
                p.drain_first = 1'b1;
            pending_pairs.push_back(p);
        end

        @(posedge rst_n);
        while (pending_pairs.size() != 0 || s_tvalid)
            @(posedge clk);
        while (exp_crossings.size() != 0)
            @(posedge clk);
        // Watch for stray results after the last one.
        repeat (SETTLE) @(posedge clk);

        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sip_pkg.sv
design/sip_div.sv
design/segment_intersection_point_core.sv
design/sip_chk.sv
tb/sv/tb.sv
